FILE: sv/assert_macros.svh
// Assertion macros used by alarm_time_match_table.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/atmt_pkg.sv
// Types, codes and widths for the alarm time match table
`default_nettype none

package atmt_pkg;

   localparam int DEF_TABLE_DEPTH = 8;

   localparam int OP_W        = 2;
   localparam int HOUR_W      = 5;
   localparam int MINUTE_W    = 6;
   localparam int SECOND_W    = 6;
   localparam int SLOT_W      = 6;
   localparam int STATUS_W    = 2;
   localparam int ALARM_CNT_W = 7;

   localparam int REQ_FIELDS_W = HOUR_W + MINUTE_W + SECOND_W + SLOT_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + 1 + SLOT_W + ALARM_CNT_W + 1;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE = 2'd0,
      OP_CHECK  = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BADSLOT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_MOVE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [SECOND_W-1:0] second;
      logic [MINUTE_W-1:0] minute;
      logic [HOUR_W-1:0]   hour;
   } entry_type;

endpackage

`default_nettype wire

FILE: sv/alarm_time_match_table.sv
// Alarm time match table: top level with sequencer, entry memory and result register
//
// Request channel (req_*): one beat per command. tuser carries the opcode
// (create, check, remove); tdata carries hour, minute, second and slot.
// Response channel (rsp_*): exactly one beat per request with status,
// triggered flag, triggered slot, alarm count and empty flag.
// Entries live in slots 0 .. count-1. A create appends at slot count;
// a remove, or a check that hits, moves the last entry into the freed slot.
// A check walks the slots in order through one compare unit, one slot per
// cycle, reading the entry memory through its single registered read port.
// Path through the states: create, remove of the last slot or of a bad
// slot, unknown opcodes and empty checks go EXEC then DONE; other removes
// go EXEC, MOVE, DONE; a check goes EXEC, SCAN up to the hit or the last
// slot, MOVE when the hit is not the last slot, then DONE.
// One request is in flight at a time; req_tready is high only when idle,
// so no new request is taken until the previous one has left DONE.
// A finished response waits in the output register while rsp_tready is
// low; the next request is taken meanwhile and is held in its last step.
// Synchronous reset empties the table (count zero); no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module alarm_time_match_table #(
   parameter int TABLE_DEPTH = atmt_pkg::DEF_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [4:0] time_hour, [10:5] time_minute, [16:11] time_second,
   // [22:17] entry_index, [23] zero
   input  logic [atmt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] op
   input  logic [atmt_pkg::OP_W-1:0]        req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] status, [2] triggered, [8:3] triggered_slot,
   // [15:9] alarm_count, [16] table_empty, [23:17] zero
   output logic [atmt_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import atmt_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
   localparam int HOUR_LO   = 0;
   localparam int MINUTE_LO = HOUR_LO + HOUR_W;
   localparam int SECOND_LO = MINUTE_LO + MINUTE_W;
   localparam int SLOT_LO   = SECOND_LO + SECOND_W;

   // control state
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_tvalid_ff;
   // item and working registers
   op_type                  op_ff;
   entry_type               key_ff;
   logic [SLOT_W-1:0]       idx_ff;
   logic [IDX_W-1:0]        slot_ff, slot_in;
   logic [IDX_W-1:0]        dst_ff, dst_in;
   status_type              status_ff, status_in;
   logic                    trig_ff, trig_in;
   logic [IDX_W-1:0]        tslot_ff, tslot_in;
   logic [RSP_TDATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   // entry memory
   entry_type               mem [TABLE_DEPTH];
   entry_type               mem_rdata_ff;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   entry_type               mem_wdata;
   logic [IDX_W-1:0]        rd_addr;

   logic                    req_accept;
   logic                    rsp_load;
   logic                    hit;
   logic [CNT_W-1:0]        cnt_m1;
   logic [IDX_W-1:0]        last_slot;
   logic                    full;
   logic                    idx_bad;
   logic                    idx_last;
   logic                    slot_last;
   logic                    empty_now;
   entry_type               req_key;

   assign req_accept = req_tvalid & req_tready;
   assign cnt_m1     = count_ff - CNT_W'(1);
   assign last_slot  = cnt_m1[IDX_W-1:0];
   assign full       = (count_ff == DEPTH_C);
   assign empty_now  = (count_ff == '0);
   assign idx_bad    = ({1'b0, idx_ff} >= ALARM_CNT_W'(count_ff));
   assign idx_last   = ({1'b0, idx_ff} == ALARM_CNT_W'(cnt_m1));
   assign slot_last  = (slot_ff == last_slot);

   assign req_key.hour   = req_tdata[MINUTE_LO-1:HOUR_LO];
   assign req_key.minute = req_tdata[SECOND_LO-1:MINUTE_LO];
   assign req_key.second = req_tdata[SLOT_LO-1:SECOND_LO];

   atmt_match u_match (
      .entry (mem_rdata_ff),
      .key   (key_ff),
      .hit   (hit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            case (op_ff)
               OP_REMOVE: begin
                  if (idx_bad || idx_last) state_in = S_DONE;
                  else state_in = S_MOVE;
               end
               OP_CHECK: begin
                  if (empty_now) state_in = S_DONE;
                  else state_in = S_SCAN;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_SCAN: begin
            if (hit) begin
               if (slot_last) state_in = S_DONE;
               else state_in = S_MOVE;
            end else if (slot_last) begin
               state_in = S_DONE;
            end
         end
         S_MOVE: state_in = S_DONE;
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = dst_ff;
      mem_wdata  = key_ff;
      rd_addr    = slot_ff;
      count_in   = count_ff;
      slot_in    = slot_ff;
      dst_in     = dst_ff;
      status_in  = status_ff;
      trig_in    = trig_ff;
      tslot_in   = tslot_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               status_in = ST_OK;
               trig_in   = 1'b0;
               tslot_in  = '0;
               slot_in   = '0;
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_CREATE: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[IDX_W-1:0];
                     count_in  = count_ff + CNT_W'(1);
                  end
               end
               OP_REMOVE: begin
                  if (idx_bad) begin
                     status_in = ST_BADSLOT;
                  end else if (idx_last) begin
                     count_in = cnt_m1;
                  end else begin
                     rd_addr = last_slot;
                     dst_in  = idx_ff[IDX_W-1:0];
                  end
               end
               OP_CHECK: begin
                  rd_addr = '0;
                  slot_in = '0;
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            if (hit) begin
               trig_in  = 1'b1;
               tslot_in = slot_ff;
               if (slot_last) begin
                  count_in = cnt_m1;
               end else begin
                  // fetch the last entry to fill the hole
                  rd_addr = last_slot;
                  dst_in  = slot_ff;
               end
            end else if (!slot_last) begin
               slot_in = IDX_W'(slot_ff + 1'b1);
               rd_addr = IDX_W'(slot_ff + 1'b1);
            end
         end
         S_MOVE: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff;
            mem_wdata = mem_rdata_ff;
            count_in  = cnt_m1;
         end
         S_DONE: begin
            rsp_load = ~rsp_tvalid_ff | rsp_tready;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_tdata_in = '0;
      rsp_tdata_in[STATUS_W-1:0]                 = status_ff;
      rsp_tdata_in[STATUS_W]                     = trig_ff;
      rsp_tdata_in[STATUS_W+1 +: SLOT_W]         = SLOT_W'(tslot_ff);
      rsp_tdata_in[STATUS_W+1+SLOT_W +: ALARM_CNT_W] = ALARM_CNT_W'(count_ff);
      rsp_tdata_in[STATUS_W+1+SLOT_W+ALARM_CNT_W] = empty_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= op_type'(req_tuser);
         key_ff <= req_key;
         idx_ff <= req_tdata[SLOT_LO +: SLOT_W];
      end
      slot_ff   <= slot_in;
      dst_ff    <= dst_in;
      status_ff <= status_in;
      trig_ff   <= trig_in;
      tslot_ff  <= tslot_in;
      if (rsp_load) rsp_tdata_ff <= rsp_tdata_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `ASSERT_HOLDS(a_count_range, clock, reset, count_ff <= DEPTH_C, "alarm count above depth")
   `ASSERT_IMPLIES(a_scan_slot, clock, reset, state_ff == S_SCAN, ALARM_CNT_W'(slot_ff) < ALARM_CNT_W'(count_ff), "scan slot beyond count")
   `ASSERT_IMPLIES(a_move_target, clock, reset, state_ff == S_MOVE, (dst_ff != last_slot) && !empty_now, "move into last or empty slot")
   `ASSERT_NEXT(a_accept_exec, clock, reset, req_accept, state_ff == S_EXEC, "accepted beat not executed")

endmodule

`default_nettype wire

FILE: sv/atmt_match.sv
// Shared time compare unit: one stored entry against the search key
`default_nettype none

module atmt_match (
   input  atmt_pkg::entry_type entry,
   input  atmt_pkg::entry_type key,
   output logic                hit
);
   import atmt_pkg::*;

   logic hour_eq;
   logic minute_eq;
   logic second_eq;

   assign hour_eq   = (entry.hour == key.hour);
   assign minute_eq = (entry.minute == key.minute);
   assign second_eq = (entry.second == key.second);
   assign hit       = hour_eq & minute_eq & second_eq;

endmodule

`default_nettype wire
